>>> sv/flg_pkg.sv
`default_nettype none

package flg_pkg;

    localparam int LINE_FRAMES_DEF = 4096;

    // item queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam int ADDR_W = 5;

    // sample_format bit positions
    localparam int FMT_UNSIGNED_BIT = 0;
    localparam int FMT_EIGHT_BIT    = 1;

    localparam logic [14:0] WET_MIX_DRY_MAX = 15'd328;

    localparam logic [27:0]        MIN_DELAY_RST  = 28'd65536;
    localparam logic [27:0]        SWEEP_SPAN_RST = 28'd0;
    localparam logic [31:0]        PHASE_STEP_RST = 32'd0;
    localparam logic signed [15:0] FEEDBACK_RST   = 16'sd16383;
    localparam logic [14:0]        WET_MIX_RST    = 15'd16383;
    localparam logic               INVERT_RST     = 1'b0;
    localparam logic [1:0]         FORMAT_RST     = 2'd0;

    typedef enum logic [2:0] {
        REG_MIN_DELAY  = 3'd0,
        REG_SWEEP_SPAN = 3'd1,
        REG_PHASE_STEP = 3'd2,
        REG_FEEDBACK   = 3'd3,
        REG_WET_MIX    = 3'd4,
        REG_INVERT     = 3'd5,
        REG_FORMAT     = 3'd6
    } flg_reg_t;

    typedef struct packed {
        logic [27:0]        min_delay_q16;
        logic [27:0]        sweep_span_q16;
        logic [31:0]        phase_step;
        logic signed [15:0] feedback_gain;
        logic [14:0]        wet_mix;
        logic               invert_wet;
        logic [1:0]         sample_format;
    } flg_cfg_t;

    typedef struct packed {
        logic               channel;
        logic signed [15:0] dry;
    } flg_item_t;

    typedef struct packed {
        logic             valid;
        logic [QCW-1:0]   count;
    } flg_q_stat_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } flg_back_stat_t;

endpackage

`default_nettype wire

>>> sv/flg_regs.sv
`default_nettype none

module flg_regs
    import flg_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output flg_cfg_t               cfg
);

    flg_cfg_t cfg_reg;
    flg_reg_t idx;
    logic     wr_en;

    assign idx    = flg_reg_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_delay_q16  <= MIN_DELAY_RST;
            cfg_reg.sweep_span_q16 <= SWEEP_SPAN_RST;
            cfg_reg.phase_step     <= PHASE_STEP_RST;
            cfg_reg.feedback_gain  <= FEEDBACK_RST;
            cfg_reg.wet_mix        <= WET_MIX_RST;
            cfg_reg.invert_wet     <= INVERT_RST;
            cfg_reg.sample_format  <= FORMAT_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_MIN_DELAY:  cfg_reg.min_delay_q16  <= pwdata[27:0];
                REG_SWEEP_SPAN: cfg_reg.sweep_span_q16 <= pwdata[27:0];
                REG_PHASE_STEP: cfg_reg.phase_step     <= pwdata;
                REG_FEEDBACK:   cfg_reg.feedback_gain  <= $signed(pwdata[15:0]);
                REG_WET_MIX:    cfg_reg.wet_mix        <= pwdata[14:0];
                REG_INVERT:     cfg_reg.invert_wet     <= pwdata[0];
                REG_FORMAT:     cfg_reg.sample_format  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_MIN_DELAY:  prdata = {4'h0, cfg_reg.min_delay_q16};
            REG_SWEEP_SPAN: prdata = {4'h0, cfg_reg.sweep_span_q16};
            REG_PHASE_STEP: prdata = cfg_reg.phase_step;
            REG_FEEDBACK:   prdata = {16'h0000, cfg_reg.feedback_gain};
            REG_WET_MIX:    prdata = {17'h00000, cfg_reg.wet_mix};
            REG_INVERT:     prdata = {31'h0, cfg_reg.invert_wet};
            REG_FORMAT:     prdata = {30'h0, cfg_reg.sample_format};
            default:        prdata = 32'h0;
        endcase
    end

endmodule

`default_nettype wire

>>> sv/flg_front.sv
`default_nettype none

module flg_front
    import flg_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [15:0]    s_tdata,    // in_sample
    input  wire logic           s_tuser,    // channel_sel
    input  wire logic [1:0]     sample_format,
    input  wire flg_back_stat_t bstat,
    output flg_item_t           item,
    output flg_q_stat_t         qstat
);

    flg_item_t          q_reg [QDEPTH];
    logic [QPW-1:0]     wr_ptr_reg;
    logic [QPW-1:0]     rd_ptr_reg;
    logic [QCW-1:0]     count_reg;
    logic [QCW-1:0]     count_next;
    logic               push;
    logic               pop;
    logic               unsig;
    logic [7:0]         byte_in;
    logic [15:0]        word_in;
    flg_item_t          conv;

    assign unsig = sample_format[FMT_UNSIGNED_BIT];

    // offset-convert unsigned formats, sign-extend 8-bit ones
    always_comb begin
        byte_in      = s_tdata[7:0] ^ {unsig, 7'b0};
        word_in      = s_tdata ^ {unsig, 15'b0};
        conv.channel = s_tuser;
        if (sample_format[FMT_EIGHT_BIT]) begin
            conv.dry = $signed({{8{byte_in[7]}}, byte_in});
        end else begin
            conv.dry = $signed(word_in);
        end
    end

    assign s_tready = (count_reg != QCW'(QDEPTH)) && !bstat.clearing;
    assign push     = s_tvalid && s_tready;
    assign pop      = bstat.pop;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= conv;
        end
    end

    assign item        = q_reg[rd_ptr_reg];
    assign qstat.valid = (count_reg != '0);
    assign qstat.count = count_reg;

endmodule

`default_nettype wire

>>> sv/flg_back.sv
`default_nettype none

module flg_back
    import flg_pkg::*;
#(
    parameter int LINE_FRAMES = LINE_FRAMES_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire flg_cfg_t       cfg,
    input  wire flg_item_t      item,
    input  wire flg_q_stat_t    qstat,
    output flg_back_stat_t      bstat,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [15:0]         m_tdata     // out_sample
);

    localparam int AW    = $clog2(LINE_FRAMES);
    localparam int DEPTH = 2 * LINE_FRAMES;
    localparam int MW    = $clog2(DEPTH);
    localparam logic [32:0] Q_ONE = 33'd65536;
    localparam logic [32:0] DMAX  = 33'(LINE_FRAMES - 2) << 16;
    localparam logic [AW:0] FR    = (AW + 1)'(LINE_FRAMES);

    typedef enum logic [8:0] {
        S_CLR  = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_MUL  = 9'b000000100,
        S_DLY  = 9'b000001000,
        S_ADR  = 9'b000010000,
        S_RD   = 9'b000100000,
        S_WET  = 9'b001000000,
        S_PRD  = 9'b010000000,
        S_WR   = 9'b100000000
    } state_t;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] x);
        logic signed [15:0] r;
        if (x > 18'sd32767) begin
            r = 16'sh7fff;
        end else if (x < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = x[15:0];
        end
        return r;
    endfunction

    function automatic logic [7:0] sat8(input logic signed [15:0] x);
        logic [7:0] r;
        if (x > 16'sd127) begin
            r = 8'h7f;
        end else if (x < -16'sd128) begin
            r = 8'h80;
        end else begin
            r = x[7:0];
        end
        return r;
    endfunction

    state_t                 state_reg;
    state_t                 state_next;
    logic [MW-1:0]          clr_cnt_reg;
    logic [31:0]            phase_reg [2];
    logic [AW-1:0]          wpos_reg [2];
    logic                   out_valid_reg;
    logic [15:0]            out_reg;

    logic                   ch_reg;
    logic signed [15:0]     dry_reg;
    logic [15:0]            tri_reg;
    logic [43:0]            span_prod_reg;
    logic [AW-1:0]          dint_reg;
    logic [15:0]            dfrac_reg;
    logic [AW-1:0]          w_reg;
    logic signed [15:0]     rd0_reg;
    logic signed [15:0]     rd1_reg;
    logic signed [33:0]     ip_reg;
    logic signed [15:0]     wet_reg;
    logic signed [31:0]     fbp_reg;
    logic signed [31:0]     mxp_reg;

    logic signed [15:0]     line_mem [DEPTH];

    logic                   out_free;
    logic                   pop;
    logic [31:0]            ph_sum;
    logic [15:0]            tri_val;
    logic [28:0]            dq;
    logic [32:0]            dqc;
    logic [AW-1:0]          w;
    logic [AW:0]            r0s;
    logic [AW-1:0]          r0;
    logic [AW-1:0]          r1;
    logic [MW-1:0]          ra0;
    logic [MW-1:0]          ra1;
    logic [MW-1:0]          wa;
    logic                   mem_we;
    logic [MW-1:0]          mem_wa;
    logic signed [15:0]     mem_wd;
    logic                   rd_en;
    logic signed [16:0]     diff_s;
    logic signed [16:0]     frac_s;
    logic signed [17:0]     wet_sum;
    logic signed [15:0]     gain_s;
    logic signed [15:0]     mix_s;
    logic signed [15:0]     item_dry;
    logic signed [15:0]     fb;
    logic signed [15:0]     ww;
    logic signed [15:0]     wr_data;
    logic signed [17:0]     mixed;
    logic signed [15:0]     word;
    logic [7:0]             out_byte;
    logic [15:0]            out_word;
    logic                   unsig;

    assign out_free = !out_valid_reg || m_tready;
    assign pop      = (state_reg == S_IDLE) && qstat.valid;
    assign unsig    = cfg.sample_format[FMT_UNSIGNED_BIT];
    assign gain_s   = cfg.feedback_gain;
    assign mix_s    = $signed({1'b0, cfg.wet_mix});
    assign item_dry = item.dry;

    // lfo advance and triangle fold
    assign ph_sum  = phase_reg[item.channel] + cfg.phase_step;
    assign tri_val = ph_sum[31] ? ~ph_sum[30:15] : ph_sum[30:15];

    // delay clamp to 1.0 .. LINE_FRAMES-2 frames
    always_comb begin
        dq  = {1'b0, cfg.min_delay_q16} + {1'b0, span_prod_reg[43:16]};
        dqc = 33'(dq);
        if (dqc < Q_ONE) begin
            dqc = Q_ONE;
        end else if (dqc > DMAX) begin
            dqc = DMAX;
        end
    end

    // tap addresses inside the channel's ring
    always_comb begin
        w   = wpos_reg[ch_reg];
        r0s = {1'b0, w} + FR - {1'b0, dint_reg};
        r0  = (r0s >= FR) ? AW'(r0s - FR) : AW'(r0s);
        r1  = (r0 == '0) ? AW'(LINE_FRAMES - 1) : r0 - 1'b1;
        ra0 = ch_reg ? MW'(r0) + MW'(LINE_FRAMES) : MW'(r0);
        ra1 = ch_reg ? MW'(r1) + MW'(LINE_FRAMES) : MW'(r1);
        wa  = ch_reg ? MW'(w_reg) + MW'(LINE_FRAMES) : MW'(w_reg);
    end

    assign diff_s  = {rd1_reg[15], rd1_reg} - {rd0_reg[15], rd0_reg};
    assign frac_s  = $signed({1'b0, dfrac_reg});
    assign wet_sum = 18'(rd0_reg) + 18'(ip_reg >>> 16);

    // write-back and mix-down
    always_comb begin
        fb      = sat16(18'(fbp_reg >>> 15));
        wr_data = sat16(18'(dry_reg) + 18'(fb));
        ww      = sat16(18'(mxp_reg >>> 15));
        mixed   = cfg.invert_wet ? 18'(dry_reg) - 18'(ww) : 18'(dry_reg) + 18'(ww);
        word    = (cfg.wet_mix <= WET_MIX_DRY_MAX) ? dry_reg : sat16(mixed);
        out_byte = sat8(word) ^ {unsig, 7'b0};
        if (cfg.sample_format[FMT_EIGHT_BIT]) begin
            out_word = {8'h00, out_byte};
        end else begin
            out_word = word ^ {unsig, 15'b0};
        end
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = wa;
        mem_wd = wr_data;
        if (state_reg == S_CLR) begin
            mem_we = 1'b1;
            mem_wa = clr_cnt_reg;
            mem_wd = '0;
        end else if ((state_reg == S_WR) && out_free) begin
            mem_we = 1'b1;
        end
    end

    assign rd_en = (state_reg == S_ADR);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            rd0_reg <= line_mem[ra0];
            rd1_reg <= line_mem[ra1];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:  if (clr_cnt_reg == MW'(DEPTH - 1)) state_next = S_IDLE;
            S_IDLE: if (qstat.valid) state_next = S_MUL;
            S_MUL:  state_next = S_DLY;
            S_DLY:  state_next = S_ADR;
            S_ADR:  state_next = S_RD;
            S_RD:   state_next = S_WET;
            S_WET:  state_next = S_PRD;
            S_PRD:  state_next = S_WR;
            S_WR:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            phase_reg[0]  <= '0;
            phase_reg[1]  <= '0;
            wpos_reg[0]   <= '0;
            wpos_reg[1]   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (pop) begin
                phase_reg[item.channel] <= ph_sum;
            end
            if (state_reg == S_ADR) begin
                wpos_reg[ch_reg] <= (w == AW'(LINE_FRAMES - 1)) ? '0 : w + 1'b1;
            end
            if ((state_reg == S_WR) && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            ch_reg  <= item.channel;
            dry_reg <= item_dry;
            tri_reg <= tri_val;
        end
        if (state_reg == S_MUL) begin
            span_prod_reg <= cfg.sweep_span_q16 * tri_reg;
        end
        if (state_reg == S_DLY) begin
            dint_reg  <= dqc[16 +: AW];
            dfrac_reg <= dqc[15:0];
        end
        if (state_reg == S_ADR) begin
            w_reg <= w;
        end
        if (state_reg == S_RD) begin
            ip_reg <= diff_s * frac_s;
        end
        if (state_reg == S_WET) begin
            // interpolated value lies between the two taps
            wet_reg <= wet_sum[15:0];
        end
        if (state_reg == S_PRD) begin
            fbp_reg <= wet_reg * gain_s;
            mxp_reg <= wet_reg * mix_s;
        end
        if ((state_reg == S_WR) && out_free) begin
            out_reg <= out_word;
        end
    end

    assign bstat.pop      = pop;
    assign bstat.clearing = (state_reg == S_CLR);
    assign m_tvalid       = out_valid_reg;
    assign m_tdata        = out_reg;

endmodule

`default_nettype wire

>>> sv/audio_flanger.sv
// each item passes through the back-end sequencer in turn (lfo, sweep multiply, delay clamp,
//   tap read, interpolation, wet add, gain multiplies, write-back) before m_tvalid rises;
//   the back end takes no new item until the last one is written back
// a 2-entry item queue lets s_tready stay high while a result waits on m_tready
// reset: registers at their reset values, lfo phases and write positions zero; a clearing
//   pass over all 2*LINE_FRAMES entries (8192 by default) zeroes the delay line, s_tready low
`default_nettype none

module audio_flanger
    import flg_pkg::*;
#(
    parameter int LINE_FRAMES = LINE_FRAMES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,    // in_sample
    input  wire logic              s_tuser,    // channel_sel
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata,    // out_sample
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    flg_cfg_t       cfg;
    flg_item_t      item;
    flg_q_stat_t    qstat;
    flg_back_stat_t bstat;

    flg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    flg_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .sample_format (cfg.sample_format),
        .bstat         (bstat),
        .item          (item),
        .qstat         (qstat)
    );

    flg_back #(
        .LINE_FRAMES (LINE_FRAMES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .item     (item),
        .qstat    (qstat),
        .bstat    (bstat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        bstat.clearing |-> !s_tready)
        else $error("item accepted during delay line clear");

    a_accept_fills_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> qstat.count != '0)
        else $error("accepted item missing from queue");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.count <= QCW'(QDEPTH))
        else $error("item queue overflow");

    a_byte_high_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && cfg.sample_format[FMT_EIGHT_BIT] |-> m_tdata[15:8] == 8'h00)
        else $error("8-bit result with nonzero high byte");

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import flg_pkg::*;

    localparam int FRAMES     = LINE_FRAMES_DEF;
    localparam int IDLE_LIMIT = 50000;

    class flanger_scoreboard;
        flg_cfg_t    cfg;
        logic [31:0] lfo_acc [2];
        int unsigned wr_pos [2];
        shortint     echo_mem [2*FRAMES];
        logic [15:0] expected_out [$];
        int          errors;

        function new();
            cfg.min_delay_q16  = MIN_DELAY_RST;
            cfg.sweep_span_q16 = SWEEP_SPAN_RST;
            cfg.phase_step     = PHASE_STEP_RST;
            cfg.feedback_gain  = FEEDBACK_RST;
            cfg.wet_mix        = WET_MIX_RST;
            cfg.invert_wet     = INVERT_RST;
            cfg.sample_format  = FORMAT_RST;
            lfo_acc = '{32'd0, 32'd0};
            wr_pos  = '{0, 0};
            foreach (echo_mem[i]) echo_mem[i] = 0;
            errors = 0;
        endfunction

        function void set_reg(flg_reg_t r, logic [31:0] v);
            case (r)
                REG_MIN_DELAY:  cfg.min_delay_q16  = v[27:0];
                REG_SWEEP_SPAN: cfg.sweep_span_q16 = v[27:0];
                REG_PHASE_STEP: cfg.phase_step     = v;
                REG_FEEDBACK:   cfg.feedback_gain  = v[15:0];
                REG_WET_MIX:    cfg.wet_mix        = v[14:0];
                REG_INVERT:     cfg.invert_wet     = v[0];
                REG_FORMAT:     cfg.sample_format  = v[1:0];
                default: ;
            endcase
        endfunction

        function longint clip(longint x, longint lo, longint hi);
            if (x < lo) return lo;
            if (x > hi) return hi;
            return x;
        endfunction

        function logic [15:0] flange(bit ch, logic [15:0] raw);
            longint      dry, s0, s1, wet, gain, fb_term, wet_term, mixed;
            logic [16:0] tri_val;
            logic [63:0] dq;
            int unsigned dint, dfrac, w, r0, r1, base;
            logic [7:0]  b;
            logic [15:0] v;
            bit          eight, unsgn;
            eight = cfg.sample_format[FMT_EIGHT_BIT];
            unsgn = cfg.sample_format[FMT_UNSIGNED_BIT];
            if (eight) begin
                b = raw[7:0] ^ (unsgn ? 8'h80 : 8'h00);
                dry = longint'($signed(b));
            end else begin
                v = raw ^ (unsgn ? 16'h8000 : 16'h0000);
                dry = longint'($signed(v));
            end

            // lfo phase folded to a 16-bit triangle
            lfo_acc[ch] = lfo_acc[ch] + cfg.phase_step;
            tri_val = lfo_acc[ch][31:15];
            if (tri_val > 17'd65535) tri_val = 17'd131071 - tri_val;

            dq = 64'(cfg.min_delay_q16) + ((64'(cfg.sweep_span_q16) * 64'(tri_val)) >> 16);
            if (dq < 64'd65536) dq = 64'd65536;
            if (dq > (64'(FRAMES - 2) << 16)) dq = 64'(FRAMES - 2) << 16;
            dint  = dq[47:16];
            dfrac = 32'(dq[15:0]);

            base = ch ? FRAMES : 0;
            w    = wr_pos[ch];
            r0   = (w + FRAMES - dint) % FRAMES;
            r1   = (r0 == 0) ? FRAMES - 1 : r0 - 1;
            s0   = echo_mem[base + r0];
            s1   = echo_mem[base + r1];
            wet  = s0 + (((s1 - s0) * longint'(dfrac)) >>> 16);

            gain    = longint'($signed(cfg.feedback_gain));
            fb_term = clip((wet * gain) >>> 15, -32768, 32767);
            echo_mem[base + w] = shortint'(clip(dry + fb_term, -32768, 32767));
            wr_pos[ch] = (w + 1 == FRAMES) ? 0 : w + 1;

            if (cfg.wet_mix <= WET_MIX_DRY_MAX) begin
                mixed = dry;
            end else begin
                wet_term = clip((wet * longint'(cfg.wet_mix)) >>> 15, -32768, 32767);
                mixed = clip(cfg.invert_wet ? dry - wet_term : dry + wet_term, -32768, 32767);
            end

            if (eight) begin
                b = 8'(clip(mixed, -128, 127)) ^ (unsgn ? 8'h80 : 8'h00);
                return {8'h00, b};
            end
            v = 16'(mixed) ^ (unsgn ? 16'h8000 : 16'h0000);
            return v;
        endfunction

        function void note_sample(bit ch, logic [15:0] raw);
            expected_out.push_back(flange(ch, raw));
        endfunction

        function void check_word(logic [15:0] got);
            logic [15:0] want;
            if (expected_out.size() == 0) begin
                errors++;
                if (errors <= 50)
                    $display("%0t: out_sample %h arrived with nothing expected", $time, got);
            end else begin
                want = expected_out.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 50)
                        $display("%0t: out_sample expected %h actual %h", $time, want, got);
                end
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [15:0]       s_tdata;    // in_sample
    logic              s_tuser;    // channel_sel
    logic              m_tvalid;
    logic              m_tready;
    logic [15:0]       m_tdata;    // out_sample
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    flanger_scoreboard sb;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                hold_cycles;
    int                idle_count;

    logic [15:0] corner_words [10] = '{16'h0000, 16'hffff, 16'h8000, 16'h7fff, 16'h00ff,
                                       16'h0080, 16'h007f, 16'h0001, 16'hff00, 16'h5aa5};

    audio_flanger i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: random stalls, plus a long hold-off when requested
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_word(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_sample(bit ch, logic [15:0] raw);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ch;
        s_tdata  <= raw;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        sb.note_sample(ch, raw);
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic send_random();
        bit          ch;
        logic [15:0] raw;
        ch = 1'($urandom_range(0, 1));
        // full-scale words now and then to push feedback and mix into saturation
        if ($urandom_range(0, 7) == 0)
            raw = corner_words[$urandom_range(0, 6)];
        else
            raw = 16'($urandom);
        send_sample(ch, raw);
    endtask

    task automatic reg_write(flg_reg_t r, logic [31:0] v);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(r, v);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.expected_out.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    // unused upper bits get random junk, which the block must ignore
    function automatic logic [31:0] with_junk(logic [31:0] v, int w);
        logic [31:0] junk;
        junk = $urandom;
        if (w >= 32) return v;
        return (v & ((32'd1 << w) - 1)) | (junk << w);
    endfunction

    task automatic program_phase(int p);
        logic [31:0] min_d, span, step, fb, mix, inv, fmt;
        case (p)
            0: begin
                min_d = 0; span = 0; step = 0; fb = 32'h8000; mix = 0; inv = 0; fmt = 2;
            end
            1: begin
                min_d = 32'h0fff_ffff; span = 32'h0fff_ffff; step = 32'hffff_ffff;
                fb = 32'h7fff; mix = 32'h7fff; inv = 1; fmt = 3;
            end
            2: begin
                min_d = 65536; span = 268238848; step = 32'h8000_0000;
                fb = 32'(16'(-31128)); mix = 329; inv = 0; fmt = 1;
            end
            default: begin
                min_d = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4094 << 16)
                                                    : $urandom_range(0, 48 << 16);
                span  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 96 << 16);
                step  = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 26);
                fb    = $urandom;
                mix   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 400) : $urandom;
                inv   = $urandom;
                fmt   = p % 4;
                min_d = with_junk(min_d, 28);
                span  = with_junk(span, 28);
                fb    = with_junk(fb, 16);
                mix   = with_junk(mix, 15);
                inv   = with_junk(inv, 1);
                fmt   = with_junk(fmt, 2);
            end
        endcase
        reg_write(REG_MIN_DELAY, min_d);
        reg_write(REG_SWEEP_SPAN, span);
        reg_write(REG_PHASE_STEP, step);
        reg_write(REG_FEEDBACK, fb);
        reg_write(REG_WET_MIX, mix);
        reg_write(REG_INVERT, inv);
        reg_write(REG_FORMAT, fmt);
    endtask

    initial begin
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        idle_count     = 0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // corner words on both channels at the reset settings
        foreach (corner_words[i]) begin
            send_sample(1'b0, corner_words[i]);
            send_sample(1'b1, corner_words[i]);
        end
        stop_sending();

        for (int p = 0; p < 10; p++) begin
            wait_drained();
            program_phase(p);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            // receiver holds off long enough for the queue to back up into s_tready
            if (p == 4) hold_cycles = 400;
            repeat (200) send_random();
            stop_sending();
        end

        wait_drained();
        if (sb.errors == 0 && sb.expected_out.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
